// ----- hw/rtl/sgm_pkg.sv -----
// ----------------------------------------------------------------------------
// sgm_pkg
// Types and fixed constants shared by the Sobel gradient magnitude block.
// ----------------------------------------------------------------------------
package sgm_pkg;

    // Configuration port
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 13;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // Plane geometry
    localparam int MIN_DIM      = 3;
    localparam int HEIGHT_MAX   = 4096;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int ROW_BITS     = 12;

    // Result fields
    localparam int MAG_BITS   = 12;
    localparam int COORD_BITS = 12;

    // Scaling by 256 gives four fraction bits after the square root.
    localparam int FRAC_SHIFT = 8;

    // Position tag that travels with a result through the pipeline.
    typedef struct packed {
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] row;
        logic                  plane_end;
    } sgm_meta_t;

endpackage

// ----- hw/rtl/sobel_gradient_magnitude.sv -----
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude: 3x3 Sobel gradient magnitude over a pixel stream
// Throughput: one pixel per cycle while the output is not stalled.
// out_valid rises once its pixel transfer has passed the kernel, square,
// square root and divide registers; the square root resolves one bit per stage.
// Reset clears counters and valid bits; line stores stay unwritten, no sweep.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude #(
    parameter int MAX_WIDTH  = 4096,
    parameter int PIXEL_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [sgm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [sgm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [PIXEL_BITS-1:0]              pixel,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [sgm_pkg::MAG_BITS-1:0]       magnitude,
    output logic [sgm_pkg::COORD_BITS-1:0]     column,
    output logic [sgm_pkg::COORD_BITS-1:0]     row,
    output logic                               plane_end
);

    import sgm_pkg::*;

    localparam int CW          = $clog2(MAX_WIDTH);
    localparam int WIDTH_RST   = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int ABS_BITS    = PIXEL_BITS + 2;
    localparam int GW          = PIXEL_BITS + 4;
    localparam int SQ_BITS     = 2 * ABS_BITS;
    localparam int ROOT_BITS   = PIXEL_BITS + 7;
    localparam int VAL_BITS    = 2 * ROOT_BITS;
    localparam int DIV_SHIFT   = ROOT_BITS + 3;
    localparam int DIV_RECIP   = ((1 << DIV_SHIFT) + 8) / 9;
    localparam int RECIP_BITS  = DIV_SHIFT - 2;
    localparam int PROD_BITS   = ROOT_BITS + RECIP_BITS;

    // Geometry and position
    logic [CW-1:0]        col_last_reg;
    logic [ROW_BITS-1:0]  row_last_reg;
    logic [CW-1:0]        col_last_cfg;
    logic [ROW_BITS-1:0]  row_last_cfg;
    logic [CW-1:0]        col_reg;
    logic [CW-1:0]        col_next;
    logic [ROW_BITS-1:0]  row_reg;
    logic [ROW_BITS-1:0]  row_next;
    logic [31:0]          cfg_value;

    // Handshake
    logic                 adv;
    logic                 accept;

    // Line stores and window
    logic [PIXEL_BITS-1:0] top_rd;
    logic [PIXEL_BITS-1:0] mid_rd;
    logic [PIXEL_BITS-1:0] win_reg [6];

    // Kernel stage
    logic [GW-1:0]        sum_left;
    logic [GW-1:0]        sum_right;
    logic [GW-1:0]        sum_upper;
    logic [GW-1:0]        sum_lower;
    logic [GW-1:0]        gx;
    logic [GW-1:0]        gy;
    logic [CW-1:0]        col_m1;
    logic [ROW_BITS-1:0]  row_m1;
    logic                 interior;
    sgm_meta_t            meta_now;
    logic [ABS_BITS-1:0]  ax_reg;
    logic [ABS_BITS-1:0]  ay_reg;
    sgm_meta_t            s1_meta_reg;
    logic                 s1_valid_reg;

    // Square stage
    logic [SQ_BITS:0]     sq_sum;
    logic [VAL_BITS-1:0]  s2_value_reg;
    sgm_meta_t            s2_meta_reg;
    logic                 s2_valid_reg;

    // Root and output
    logic                 root_valid;
    logic [ROOT_BITS-1:0] root;
    sgm_meta_t            root_meta;
    logic [PROD_BITS-1:0] quot_prod;
    logic                 out_valid_reg;
    logic [MAG_BITS-1:0]  magnitude_reg;
    sgm_meta_t            out_meta_reg;

    // ------------------------------------------------------------------
    // Configuration: sizes are clamped at write time and kept as last index.
    // ------------------------------------------------------------------
    assign cfg_value = 32'(cfg_data);

    always_comb
    begin
        if (cfg_value < 32'(MIN_DIM))
        begin
            col_last_cfg = CW'(MIN_DIM - 1);
        end
        else if (cfg_value > 32'(MAX_WIDTH))
        begin
            col_last_cfg = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            col_last_cfg = CW'(cfg_value - 32'd1);
        end

        if (cfg_value < 32'(MIN_DIM))
        begin
            row_last_cfg = ROW_BITS'(MIN_DIM - 1);
        end
        else if (cfg_value > 32'(HEIGHT_MAX))
        begin
            row_last_cfg = ROW_BITS'(HEIGHT_MAX - 1);
        end
        else
        begin
            row_last_cfg = ROW_BITS'(cfg_value - 32'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_last_reg <= CW'(WIDTH_RST - 1);
            row_last_reg <= ROW_BITS'(HEIGHT_RESET - 1);
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  col_last_reg <= col_last_cfg;
                REG_FRAME_HEIGHT: row_last_reg <= row_last_cfg;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: the whole pipeline moves unless a finished result is held.
    // ------------------------------------------------------------------
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;
    assign accept   = in_valid && adv;

    // ------------------------------------------------------------------
    // Position counters. The line stores are read at the next position so
    // the column's entries are ready when its pixel transfer happens.
    // ------------------------------------------------------------------
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_write)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == col_last_reg)
            begin
                col_next = '0;
                row_next = (row_reg == row_last_reg) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    sgm_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_upper (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (mid_rd),
        .rd_addr (col_next),
        .rd_data (top_rd)
    );

    sgm_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_middle (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (pixel),
        .rd_addr (col_next),
        .rd_data (mid_rd)
    );

    // Window: entries 0..2 hold the column two to the left, 3..5 the column
    // just to the left, each as upper, middle, current row.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_rd;
            win_reg[4] <= mid_rd;
            win_reg[5] <= pixel;
        end
    end

    // ------------------------------------------------------------------
    // Kernel stage
    // ------------------------------------------------------------------
    always_comb
    begin
        sum_right = GW'(top_rd) + (GW'(mid_rd) << 1) + GW'(pixel);
        sum_left  = GW'(win_reg[0]) + (GW'(win_reg[1]) << 1) + GW'(win_reg[2]);
        sum_lower = GW'(win_reg[2]) + (GW'(win_reg[5]) << 1) + GW'(pixel);
        sum_upper = GW'(win_reg[0]) + (GW'(win_reg[3]) << 1) + GW'(top_rd);
        gx        = sum_right - sum_left;
        gy        = sum_lower - sum_upper;

        col_m1    = col_reg - 1'b1;
        row_m1    = row_reg - 1'b1;
        interior  = (col_reg >= CW'(2)) && (row_reg >= ROW_BITS'(2));

        meta_now.column    = COORD_BITS'(col_m1);
        meta_now.row       = COORD_BITS'(row_m1);
        meta_now.plane_end = (col_reg == col_last_reg) && (row_reg == row_last_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= accept && interior;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= root_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg      <= gx[GW-1] ? ABS_BITS'(~gx + 1'b1) : ABS_BITS'(gx);
            ay_reg      <= gy[GW-1] ? ABS_BITS'(~gy + 1'b1) : ABS_BITS'(gy);
            s1_meta_reg <= meta_now;
        end
    end

    // ------------------------------------------------------------------
    // Square stage: the sum of squares scaled for four fraction bits.
    // ------------------------------------------------------------------
    assign sq_sum = (SQ_BITS+1)'(ax_reg * ax_reg) + (SQ_BITS+1)'(ay_reg * ay_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_value_reg <= VAL_BITS'(sq_sum) << FRAC_SHIFT;
            s2_meta_reg  <= s1_meta_reg;
        end
    end

    sgm_isqrt #(
        .ROOT_BITS (ROOT_BITS)
    ) u_isqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (s2_valid_reg),
        .in_value   (s2_value_reg),
        .in_meta    (s2_meta_reg),
        .root_valid (root_valid),
        .root       (root),
        .root_meta  (root_meta)
    );

    // ------------------------------------------------------------------
    // Divide by nine through a reciprocal; exact for every root width here.
    // ------------------------------------------------------------------
    assign quot_prod = PROD_BITS'(root) * PROD_BITS'(DIV_RECIP);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            magnitude_reg <= MAG_BITS'(quot_prod >> DIV_SHIFT);
            out_meta_reg  <= root_meta;
        end
    end

    assign out_valid = out_valid_reg;
    assign magnitude = magnitude_reg;
    assign column    = out_meta_reg.column;
    assign row       = out_meta_reg.row;
    assign plane_end = out_meta_reg.plane_end;

endmodule

// ----- hw/rtl/sgm_ram.sv -----
// ----------------------------------------------------------------------------
// sgm_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module sgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/sgm_isqrt.sv -----
// ----------------------------------------------------------------------------
// sgm_isqrt
// Pipelined integer square root, one result bit per stage, with a tag.
// ----------------------------------------------------------------------------
module sgm_isqrt #(
    parameter int ROOT_BITS = 15
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [2*ROOT_BITS-1:0]   in_value,
    input  sgm_pkg::sgm_meta_t       in_meta,
    output logic                     root_valid,
    output logic [ROOT_BITS-1:0]     root,
    output sgm_pkg::sgm_meta_t       root_meta
);

    import sgm_pkg::*;

    localparam int VW = 2 * ROOT_BITS;

    logic [VW-1:0]  rem_reg   [ROOT_BITS];
    logic [VW-1:0]  res_reg   [ROOT_BITS];
    sgm_meta_t      meta_reg  [ROOT_BITS];
    logic           vld_reg   [ROOT_BITS];

    logic [VW-1:0]  rem_next  [ROOT_BITS];
    logic [VW-1:0]  res_next  [ROOT_BITS];
    sgm_meta_t      meta_next [ROOT_BITS];
    logic           vld_next  [ROOT_BITS];

    for (genvar k = 0; k < ROOT_BITS; k++)
    begin : g_stage
        localparam logic [VW-1:0] STEP_BIT = VW'(1) << (2 * (ROOT_BITS - 1 - k));

        logic [VW-1:0] rem_in;
        logic [VW-1:0] res_in;
        logic [VW:0]   trial;

        if (k == 0)
        begin : g_first
            assign rem_in       = in_value;
            assign res_in       = '0;
            assign meta_next[k] = in_meta;
            assign vld_next[k]  = in_valid;
        end
        else
        begin : g_rest
            assign rem_in       = rem_reg[k-1];
            assign res_in       = res_reg[k-1];
            assign meta_next[k] = meta_reg[k-1];
            assign vld_next[k]  = vld_reg[k-1];
        end

        assign trial = {1'b0, res_in} + {1'b0, STEP_BIT};

        always_comb
        begin
            if ({1'b0, rem_in} >= trial)
            begin
                rem_next[k] = rem_in - trial[VW-1:0];
                res_next[k] = (res_in >> 1) + STEP_BIT;
            end
            else
            begin
                rem_next[k] = rem_in;
                res_next[k] = res_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_next[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next[k];
                res_reg[k]  <= res_next[k];
                meta_reg[k] <= meta_next[k];
            end
        end
    end

    assign root_valid = vld_reg[ROOT_BITS-1];
    assign root       = res_reg[ROOT_BITS-1][ROOT_BITS-1:0];
    assign root_meta  = meta_reg[ROOT_BITS-1];

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for the Sobel gradient magnitude block
// Streams pixel planes of many sizes through the block. A behavioral model of
// the line stores, window and kernels predicts each interior result, and every
// output transfer is compared in order, field by field. Both sides idle at
// random, and register writes happen only once the output has drained.
// ----------------------------------------------------------------------------
module tb;
    import sgm_pkg::*;

    localparam int LINE_DEPTH   = 4096;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 250;

    typedef struct packed {
        logic [MAG_BITS-1:0]   magnitude;
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] row;
        logic                  plane_end;
    } grad_t;

    typedef struct packed {
        logic [7:0]          px;
        logic                typed;
        logic [MAG_BITS-1:0] magnitude;
    } stim_row_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_write = 1'b0;
    cfg_reg_t                 cfg_index = REG_FRAME_WIDTH;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic [7:0]               pixel     = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [MAG_BITS-1:0]      magnitude;
    logic [COORD_BITS-1:0]    column;
    logic [COORD_BITS-1:0]    row;
    logic                     plane_end;

    // Behavioral copy of the block state.
    logic [12:0] width_reg  = 13'(WIDTH_RESET);
    logic [12:0] height_reg = 13'(HEIGHT_RESET);
    logic [7:0]  upper_line [LINE_DEPTH] = '{default: '0};
    logic [7:0]  middle_line [LINE_DEPTH] = '{default: '0};
    logic [7:0]  win_px [6] = '{default: '0};
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;

    grad_t pending_grads [$];
    int    mismatch_count = 0;
    bit    idle_on = 1'b1;

    // Three 3x3 planes: flat, a full left-to-right step, and a corner.
    // A flat plane has no gradient; the step gives 1020 * 16 / 9 = 1813.
    stim_row_t directed_rows [27] = '{
        '{8'd0, 1'b0, 12'd0},   '{8'd0, 1'b0, 12'd0},   '{8'd0, 1'b0, 12'd0},
        '{8'd0, 1'b0, 12'd0},   '{8'd0, 1'b0, 12'd0},   '{8'd0, 1'b0, 12'd0},
        '{8'd0, 1'b0, 12'd0},   '{8'd0, 1'b0, 12'd0},   '{8'd0, 1'b1, 12'd0},
        '{8'd0, 1'b0, 12'd0},   '{8'd128, 1'b0, 12'd0}, '{8'd255, 1'b0, 12'd0},
        '{8'd0, 1'b0, 12'd0},   '{8'd128, 1'b0, 12'd0}, '{8'd255, 1'b0, 12'd0},
        '{8'd0, 1'b0, 12'd0},   '{8'd128, 1'b0, 12'd0}, '{8'd255, 1'b1, 12'd1813},
        '{8'd0, 1'b0, 12'd0},   '{8'd0, 1'b0, 12'd0},   '{8'd255, 1'b0, 12'd0},
        '{8'd0, 1'b0, 12'd0},   '{8'd77, 1'b0, 12'd0},  '{8'd255, 1'b0, 12'd0},
        '{8'd0, 1'b0, 12'd0},   '{8'd255, 1'b0, 12'd0}, '{8'd255, 1'b0, 12'd0}
    };

    sobel_gradient_magnitude u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .magnitude (magnitude),
        .column    (column),
        .row       (row),
        .plane_end (plane_end)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned clamp_dim(input logic [12:0] v, input int unsigned hi);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Mostly uniform pixels, with a share of hard black and white edges.
    function automatic logic [7:0] pick_pixel();
        if ($urandom_range(0, 9) < 3)
            return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic predict_gradient(input logic [7:0] px, input logic typed,
                                    input logic [MAG_BITS-1:0] typed_mag);
        int unsigned       w;
        int unsigned       h;
        int unsigned       ci;
        int                top;
        int                mid;
        int                cur;
        int                gx;
        int                gy;
        longint unsigned   energy;
        longint unsigned   root;
        longint unsigned   trial;
        grad_t             g;
        w = clamp_dim(width_reg, LINE_DEPTH);
        h = clamp_dim(height_reg, HEIGHT_MAX);
        ci = col_pos % LINE_DEPTH;
        top = int'(upper_line[ci]);
        mid = int'(middle_line[ci]);
        cur = int'(px);
        if (row_pos >= 2 && col_pos >= 2)
        begin
            // Right column minus left column, then bottom row minus top row.
            gx = (top + 2 * mid + cur)
                 - (int'(win_px[0]) + 2 * int'(win_px[1]) + int'(win_px[2]));
            gy = (int'(win_px[2]) + 2 * int'(win_px[5]) + cur)
                 - (int'(win_px[0]) + 2 * int'(win_px[3]) + top);
            energy = longint'(gx * gx + gy * gy) * 256;
            root = 0;
            for (int b = 31; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= energy)
                    root = trial;
            end
            g.magnitude = MAG_BITS'(root / 9);
            g.column    = COORD_BITS'(col_pos - 1);
            g.row       = COORD_BITS'(row_pos - 1);
            g.plane_end = (row_pos + 1 == h) && (col_pos + 1 == w);
            if (typed)
                g.magnitude = typed_mag;
            pending_grads.push_back(g);
        end
        win_px[0] = win_px[3];
        win_px[1] = win_px[4];
        win_px[2] = win_px[5];
        win_px[3] = upper_line[ci];
        win_px[4] = middle_line[ci];
        win_px[5] = px;
        upper_line[ci]  = middle_line[ci];
        middle_line[ci] = px;
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos++;
        end
    endtask

    task automatic send_pixel(input logic [7:0] px, input logic typed,
                              input logic [MAG_BITS-1:0] typed_mag);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= px;
        do
            @(posedge clk);
        while (in_stall);
        predict_gradient(px, typed, typed_mag);
    endtask

    task automatic wait_idle(input int settle);
        in_valid <= 1'b0;
        while (pending_grads.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Any register write also restarts the plane.
    task automatic write_frame(input logic set_w, input logic [12:0] w,
                               input logic set_h, input logic [12:0] h);
        if (set_w)
        begin
            cfg_write <= 1'b1;
            cfg_index <= REG_FRAME_WIDTH;
            cfg_data  <= w;
            @(posedge clk);
            width_reg = w;
        end
        if (set_h)
        begin
            cfg_write <= 1'b1;
            cfg_index <= REG_FRAME_HEIGHT;
            cfg_data  <= h;
            @(posedge clk);
            height_reg = h;
        end
        cfg_write <= 1'b0;
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_pixel(pick_pixel(), 1'b0, '0);
    endtask

    // Output side: random stall bursts, one long hold, and result checking.
    initial
    begin
        int    hold_left;
        int    seen;
        bit    held;
        grad_t want;
        hold_left = 0;
        seen = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                seen++;
                if (pending_grads.size() == 0)
                begin
                    $error("unexpected result: magnitude %0d column %0d row %0d",
                           magnitude, column, row);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_grads.pop_front();
                    if (magnitude !== want.magnitude)
                    begin
                        $error("magnitude: expected %0d, actual %0d",
                               want.magnitude, magnitude);
                        mismatch_count++;
                    end
                    if (column !== want.column)
                    begin
                        $error("column: expected %0d, actual %0d", want.column, column);
                        mismatch_count++;
                    end
                    if (row !== want.row)
                    begin
                        $error("row: expected %0d, actual %0d", want.row, row);
                        mismatch_count++;
                    end
                    if (plane_end !== want.plane_end)
                    begin
                        $error("plane_end: expected %0d, actual %0d",
                               want.plane_end, plane_end);
                        mismatch_count++;
                    end
                end
            end
            // Hold the output once for long enough that the block fills and
            // stalls its input while pixels keep coming.
            if (!held && seen == 40)
            begin
                held = 1'b1;
                hold_left = LONG_HOLD;
            end
            else if (hold_left == 0 && idle_on && $urandom_range(0, 7) == 0)
            begin
                hold_left = $urandom_range(1, 11);
            end
            out_stall <= (hold_left != 0);
            if (hold_left != 0)
                hold_left--;
        end
    end

    initial
    begin
        int          sent;
        int          n_items;
        int          pick;
        logic [12:0] w;
        logic [12:0] h;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_frame(1'b1, 13'd3, 1'b1, 13'd3);
        foreach (directed_rows[i])
            send_pixel(directed_rows[i].px, directed_rows[i].typed,
                       directed_rows[i].magnitude);
        wait_idle(DRAIN_CYCLES);

        // Small planes back to back; halfway the sender waits for the output
        // to drain before it goes on.
        write_frame(1'b1, 13'd5, 1'b1, 13'd4);
        for (int i = 0; i < 200; i++)
        begin
            if (i == 100)
                wait_idle(0);
            send_pixel(pick_pixel(), 1'b0, '0);
        end
        wait_idle(DRAIN_CYCLES);

        // Sizes below the minimum act as three.
        write_frame(1'b1, 13'd0, 1'b1, 13'd1);
        send_random(100);
        wait_idle(DRAIN_CYCLES);

        // The widest line, clamped from all ones; its first row only fills
        // the stores.
        write_frame(1'b1, 13'h1FFF, 1'b1, 13'd3);
        send_random(120);
        wait_idle(DRAIN_CYCLES);

        // The tallest plane, three pixels wide, over its first rows.
        write_frame(1'b1, 13'd3, 1'b1, 13'h1FFF);
        send_random(150);
        wait_idle(DRAIN_CYCLES);

        // Planes left midway, restarted by a write of one register alone.
        write_frame(1'b1, 13'd17, 1'b1, 13'd9);
        send_random(150);
        wait_idle(DRAIN_CYCLES);
        write_frame(1'b1, 13'd17, 1'b0, '0);
        send_random(100);
        wait_idle(DRAIN_CYCLES);
        write_frame(1'b0, '0, 1'b1, 13'd2);
        send_random(100);
        wait_idle(DRAIN_CYCLES);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            w = (pick == 0) ? 13'($urandom_range(0, 2)) : 13'($urandom_range(3, 40));
            h = (pick == 1) ? 13'($urandom_range(4097, 8191)) : 13'($urandom_range(0, 24));
            n_items = $urandom_range(30, 250);
            pick = $urandom_range(0, 2);
            write_frame(pick != 1, w, pick != 0, h);
            send_random(n_items);
            sent += n_items;
            wait_idle(DRAIN_CYCLES);
        end

        // Closing stretch with a transfer offered and taken on every cycle.
        idle_on = 1'b0;
        write_frame(1'b1, 13'd9, 1'b1, 13'd6);
        send_random(240);
        wait_idle(DRAIN_CYCLES);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #(40_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
